// ===== hw/rtl/hcifp_pkg.sv =====
// hci frame parser package: phase codes, result kind codes, frame constants
// and field widths. no dependencies.
package hcifp_pkg;

  localparam int unsigned PhaseW = 4;
  localparam int unsigned KindW  = 3;
  localparam int unsigned RssiW  = 10;

  // stream data widths, padded to whole bytes
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 88;

  localparam logic [7:0] StartByte = 8'h5A;

  localparam logic [PhaseW-1:0] PhSof     = 4'd0;
  localparam logic [PhaseW-1:0] PhDrop    = 4'd1;
  localparam logic [PhaseW-1:0] PhCtrl    = 4'd2;
  localparam logic [PhaseW-1:0] PhId      = 4'd3;
  localparam logic [PhaseW-1:0] PhLen     = 4'd4;
  localparam logic [PhaseW-1:0] PhPayload = 4'd5;
  localparam logic [PhaseW-1:0] PhTs      = 4'd6;
  localparam logic [PhaseW-1:0] PhRssi    = 4'd7;
  localparam logic [PhaseW-1:0] PhCrc     = 4'd8;

  localparam logic [KindW-1:0] KindPayload = 3'd0;
  localparam logic [KindW-1:0] KindTs      = 3'd1;
  localparam logic [KindW-1:0] KindRssi    = 3'd2;
  localparam logic [KindW-1:0] KindCrc     = 3'd3;
  localparam logic [KindW-1:0] KindBad     = 3'd4;

  // -120 dBm in quarter dB
  localparam logic [RssiW-1:0] RssiOffset = 10'd480;

  localparam logic [7:0] TsBytes  = 8'd4;
  localparam logic [7:0] CrcBytes = 8'd2;

endpackage

// ===== hw/rtl/hci_frame_parser_core.sv =====
// a result appears on the master side, from the output register, in the cycle after its input byte transfer
// throughput: one byte per cycle unless a result waits in the output register undrained; the next byte is
//   taken while a result waits in the output register as long as that register is drained
// reset (rst_ni low, asynchronous) returns to waiting for a start byte, clears the frame
//   flags, payload count, accumulator and byte order (big endian), and empties the output
// hci frame parser top level: deframes the byte stream into payload, timestamp, rssi and crc
//   results, and a bad result for a wrong start byte. depends on hcifp_pkg.
module hci_frame_parser_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_wr_en_i,
  input  logic                              cfg_wr_data_i,   // multi_byte_order
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [hcifp_pkg::InDataW-1:0]     s_axis_tdata,    // [7:0] rx_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] value, [35:32] endpoint, [43:36] message_id, [75:44] message_number,
  // [85:76] rssi_quarter_db, [87:86] zero
  output logic [hcifp_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic [hcifp_pkg::KindW-1:0]       m_axis_tuser,    // [2:0] kind
  output logic                              m_axis_tlast     // last
);
  import hcifp_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [7:0]        bytes_left_q, bytes_left_d;
  logic [3:0]        endpoint_q, endpoint_d;
  logic [7:0]        msg_id_q, msg_id_d;
  logic              has_crc_q, has_crc_d;
  logic              has_rssi_q, has_rssi_d;
  logic              has_ts_q, has_ts_d;
  logic [31:0]       payload_cnt_q, payload_cnt_d;
  logic [31:0]       acc_q, acc_d;
  logic              byte_order_q;

  logic              out_valid_q;
  logic [KindW-1:0]  out_kind_q;
  logic [31:0]       out_value_q;
  logic              out_last_q;
  logic [3:0]        out_endpoint_q;
  logic [7:0]        out_msg_id_q;
  logic [31:0]       out_msg_num_q;
  logic [RssiW-1:0]  out_rssi_q;

  logic              res_valid;
  logic [KindW-1:0]  res_kind;
  logic [31:0]       res_value;
  logic              res_last;
  logic [RssiW-1:0]  res_rssi;

  logic              in_fire;
  logic [7:0]        rx_byte;
  logic [7:0]        left_dec;
  logic [31:0]       ts_acc;
  logic [15:0]       crc_acc;
  logic [RssiW-1:0]  rssi_times3;

  assign rx_byte       = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign left_dec    = bytes_left_q - 8'd1;
  assign ts_acc      = {acc_q[23:0], rx_byte};
  assign crc_acc     = {acc_q[7:0], rx_byte};
  assign rssi_times3 = {1'b0, rx_byte, 1'b0} + {2'b00, rx_byte};

  always_comb begin
    phase_d       = phase_q;
    bytes_left_d  = bytes_left_q;
    endpoint_d    = endpoint_q;
    msg_id_d      = msg_id_q;
    has_crc_d     = has_crc_q;
    has_rssi_d    = has_rssi_q;
    has_ts_d      = has_ts_q;
    payload_cnt_d = payload_cnt_q;
    acc_d         = acc_q;
    res_valid     = 1'b0;
    res_kind      = KindPayload;
    res_value     = {24'd0, rx_byte};
    res_last      = 1'b0;
    res_rssi      = '0;
    unique case (phase_q)
      PhSof: begin
        if (rx_byte == StartByte) begin
          phase_d = PhCtrl;
        end else begin
          phase_d   = PhDrop;
          res_valid = 1'b1;
          res_kind  = KindBad;
        end
      end
      PhDrop: begin
        phase_d = PhSof;
      end
      PhCtrl: begin
        endpoint_d = rx_byte[3:0];
        has_crc_d  = rx_byte[7];
        has_rssi_d = rx_byte[6];
        has_ts_d   = rx_byte[5];
        phase_d    = PhId;
      end
      PhId: begin
        msg_id_d = rx_byte;
        phase_d  = PhLen;
      end
      PhLen: begin
        bytes_left_d = rx_byte;
        if (rx_byte != 8'd0) begin
          phase_d   = PhPayload;
          res_valid = 1'b1;
        end else if (has_crc_q) begin
          bytes_left_d = CrcBytes;
          acc_d        = '0;
          phase_d      = PhCrc;
        end else begin
          phase_d = PhSof;
        end
      end
      PhPayload: begin
        bytes_left_d = left_dec;
        res_valid    = 1'b1;
        if (left_dec == 8'd0) begin
          res_last      = 1'b1;
          payload_cnt_d = payload_cnt_q + 32'd1;
          if (has_ts_q) begin
            bytes_left_d = TsBytes;
            acc_d        = '0;
            phase_d      = PhTs;
          end else if (has_rssi_q) begin
            phase_d = PhRssi;
          end else if (has_crc_q) begin
            bytes_left_d = CrcBytes;
            acc_d        = '0;
            phase_d      = PhCrc;
          end else begin
            phase_d = PhSof;
          end
        end
      end
      PhTs: begin
        acc_d        = ts_acc;
        bytes_left_d = left_dec;
        if (left_dec == 8'd0) begin
          res_valid = 1'b1;
          res_kind  = KindTs;
          res_value = byte_order_q ? {ts_acc[7:0], ts_acc[15:8], ts_acc[23:16], ts_acc[31:24]}
                                   : ts_acc;
          if (has_rssi_q) begin
            phase_d = PhRssi;
          end else if (has_crc_q) begin
            bytes_left_d = CrcBytes;
            acc_d        = '0;
            phase_d      = PhCrc;
          end else begin
            phase_d = PhSof;
          end
        end
      end
      PhRssi: begin
        res_valid = 1'b1;
        res_kind  = KindRssi;
        res_rssi  = rssi_times3 - RssiOffset;
        if (has_crc_q) begin
          bytes_left_d = CrcBytes;
          acc_d        = '0;
          phase_d      = PhCrc;
        end else begin
          phase_d = PhSof;
        end
      end
      PhCrc: begin
        acc_d        = {16'd0, crc_acc};
        bytes_left_d = left_dec;
        if (left_dec == 8'd0) begin
          res_valid = 1'b1;
          res_kind  = KindCrc;
          res_value = byte_order_q ? {16'd0, crc_acc[7:0], crc_acc[15:8]}
                                   : {16'd0, crc_acc};
          phase_d   = PhSof;
        end
      end
      default: begin
        phase_d = PhSof;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhSof;
      bytes_left_q  <= '0;
      endpoint_q    <= '0;
      msg_id_q      <= '0;
      has_crc_q     <= 1'b0;
      has_rssi_q    <= 1'b0;
      has_ts_q      <= 1'b0;
      payload_cnt_q <= '0;
      acc_q         <= '0;
    end else if (in_fire) begin
      phase_q       <= phase_d;
      bytes_left_q  <= bytes_left_d;
      endpoint_q    <= endpoint_d;
      msg_id_q      <= msg_id_d;
      has_crc_q     <= has_crc_d;
      has_rssi_q    <= has_rssi_d;
      has_ts_q      <= has_ts_d;
      payload_cnt_q <= payload_cnt_d;
      acc_q         <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_order_q <= 1'b0;
    end else if (cfg_wr_en_i) begin
      byte_order_q <= cfg_wr_data_i;
    end
  end

  // output register empties when taken and refills from the same transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= in_fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_kind_q     <= res_kind;
      out_value_q    <= res_value;
      out_last_q     <= res_last;
      out_endpoint_q <= (res_kind == KindBad) ? 4'd0 : endpoint_q;
      out_msg_id_q   <= (res_kind == KindBad) ? 8'd0 : msg_id_q;
      out_msg_num_q  <= payload_cnt_q;
      out_rssi_q     <= res_rssi;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_rssi_q, out_msg_num_q, out_msg_id_q,
                          out_endpoint_q, out_value_q};

endmodule
